[hdl/mfb_pkg.sv]
// Shared constants for the mel filterbank accumulator.
// No dependencies.
package mfb_pkg;

  localparam int unsigned MaxBins   = 1024;
  localparam int unsigned EdgeW     = 10;
  localparam int unsigned PowerW    = 32;
  localparam int unsigned EnergyW   = 48;
  localparam int unsigned WeightW   = 17;   // Q1.16, up to 1.0
  localparam int unsigned QuotW     = 16;   // weights below 1.0
  localparam int unsigned NumW      = 11;   // 2*(k-l)
  localparam int unsigned DenW      = 20;   // (r-l)*(c-l)
  localparam int unsigned ProdW     = PowerW + WeightW;

  localparam logic [WeightW-1:0] WeightOne   = 17'h10000;
  localparam logic [EnergyW-1:0] EnergyMax   = {EnergyW{1'b1}};
  localparam logic [5:0]         NumFiltRst  = 6'd24;

  localparam logic OpEdge = 1'b0;
  localparam logic OpBin  = 1'b1;

  localparam logic RegNumFilters = 1'b0;

endpackage

[hdl/mfb_edge_mem.sv]
// Filter edge table: synchronous RAM, one write and one registered read port.
// Depends on mfb_pkg.
module mfb_edge_mem #(
  parameter int unsigned Depth = 34,
  parameter int unsigned AddrW = 6
) (
  input  logic                      clk_i,
  input  logic                      wr_en_i,
  input  logic [AddrW-1:0]          wr_addr_i,
  input  logic [mfb_pkg::EdgeW-1:0] wr_data_i,
  input  logic                      rd_en_i,
  input  logic [AddrW-1:0]          rd_addr_i,
  output logic [mfb_pkg::EdgeW-1:0] rd_data_o
);
  import mfb_pkg::*;

  logic [EdgeW-1:0] mem_q [Depth];
  logic [EdgeW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

[hdl/mfb_acc_mem.sv]
// Accumulator RAM with per-entry valid bits; an invalid entry reads as zero.
// Depends on mfb_pkg.
module mfb_acc_mem #(
  parameter int unsigned Depth = 32,
  parameter int unsigned AddrW = 5
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        clr_i,
  input  logic                        wr_en_i,
  input  logic [AddrW-1:0]            wr_addr_i,
  input  logic [mfb_pkg::EnergyW-1:0] wr_data_i,
  input  logic                        rd_en_i,
  input  logic [AddrW-1:0]            rd_addr_i,
  output logic [mfb_pkg::EnergyW-1:0] rd_data_o
);
  import mfb_pkg::*;

  logic [EnergyW-1:0] mem_q [Depth];
  logic [EnergyW-1:0] rd_q;
  logic [Depth-1:0]   vld_q;
  logic               rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (clr_i) begin
        vld_q <= '0;
      end else if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

[hdl/mfb_div.sv]
// Restoring divider for the triangle weight: floor(num * 2^16 / den), num < den.
// One quotient bit per cycle. Depends on mfb_pkg.
module mfb_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [mfb_pkg::NumW-1:0]  num_i,
  input  logic [mfb_pkg::DenW-1:0]  den_i,
  output logic                      done_o,
  output logic [mfb_pkg::QuotW-1:0] quot_o
);
  import mfb_pkg::*;

  localparam int unsigned CntW = $clog2(QuotW + 1);

  logic [DenW:0]    rem_q;
  logic [DenW-1:0]  den_q;
  logic [QuotW-1:0] quot_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q;
  logic [DenW:0]    rem_sh;
  logic             ge;

  assign rem_sh = {rem_q[DenW-1:0], 1'b0};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(QuotW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= (DenW + 1)'(num_i);
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? rem_sh - {1'b0, den_q} : rem_sh;
      quot_q <= {quot_q[QuotW-2:0], ge};
    end
  end

  assign done_o = busy_q && (cnt_q == CntW'(1));
  assign quot_o = {quot_q[QuotW-2:0], ge};

endmodule

[hdl/mel_filterbank_accumulator.sv]
// Mel triangular filterbank accumulator, top level.
// Depends on mfb_pkg, mfb_edge_mem, mfb_acc_mem, mfb_div.
//
// Usage: load filter edges first (operation 0, edge_slot, edge_bin), then
// stream power bins (operation 1, bin_index, power, last_bin). Each filter f
// spans edges f, f+1, f+2 and adds floor(power * weight / 2^16) into its
// accumulator, saturating at 2^48-1. On a bin with last_bin set, one item per
// filter in use is emitted (filter_number, energy, last_filter on the final
// one) and all accumulators are cleared.
// Input: accepted when in_valid_i is high and in_stall_o low. An edge load
// writes the edge RAM and leaves the input open. A bin walks all filters in
// use through the edge RAM, fetching the first edges (S_E0 to S_EVAL), then
// per filter a setup step and, for a covered one, the bit-serial weight
// divide (skipped for a single-bin filter), a multiply and an accumulator
// add; the input stays stalled until the walk ends.
// Output: emission reads one accumulator at a time; a held output item
// stalls the walk until taken. The input side reopens once the final item is
// loaded into the output register.
// Reset: num_filters returns to 24, accumulators read as zero at once (valid
// bits), the edge table holds whatever it held until written.
module mel_filterbank_accumulator #(
  parameter int unsigned MAX_FILTERS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input items
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [5:0]  edge_slot_i,
  input  logic [9:0]  edge_bin_i,
  input  logic [9:0]  bin_index_i,
  input  logic [31:0] power_i,
  input  logic        last_bin_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  filter_number_o,
  output logic [47:0] energy_o,
  output logic        last_filter_o
);
  import mfb_pkg::*;

  localparam int unsigned EdgeDepth = MAX_FILTERS + 2;
  localparam int unsigned EAW = $clog2(EdgeDepth);
  localparam int unsigned FW  = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
  localparam int unsigned NFW = $clog2(MAX_FILTERS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_E0, S_E1, S_E2, S_EVAL, S_SETUP, S_DIV, S_MUL, S_ADD, S_NEXT,
    S_EMRD, S_EMWR
  } state_e;

  state_e state_q;

  // configuration register
  logic [5:0] num_filters_q;
  logic [NFW-1:0] nf;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegNumFilters) ? {26'd0, num_filters_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_filters_q <= NumFiltRst;
    end else if (psel && penable && pwrite && (paddr[2] == RegNumFilters)) begin
      num_filters_q <= pwdata[5:0];
    end
  end

  // clamp to 1..MAX_FILTERS
  always_comb begin
    if (num_filters_q == 6'd0) begin
      nf = NFW'(1);
    end else if (32'(num_filters_q) > 32'(MAX_FILTERS)) begin
      nf = NFW'(MAX_FILTERS);
    end else begin
      nf = NFW'(num_filters_q);
    end
  end

  // working registers
  logic [FW-1:0]      f_q;
  logic [EdgeW-1:0]   l_q, c_q, r_q;
  logic [EdgeW-1:0]   k_q;
  logic [PowerW-1:0]  power_q;
  logic               last_q;
  logic [WeightW-1:0] w_q;
  logic [ProdW-1:0]   prod_q;
  logic               out_valid_q;
  logic [4:0]         fnum_q;
  logic [EnergyW-1:0] energy_q;
  logic               lastf_q;

  logic in_acc;
  logic last_f;
  logic bin_ok;
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign last_f     = (NFW'(f_q) + NFW'(1)) == nf;
  assign bin_ok     = ({22'd0, bin_index_i} < 32'(MaxBins));

  // edge RAM
  logic             e_wr, e_rd;
  logic [EAW-1:0]   e_waddr, e_raddr;
  logic [EdgeW-1:0] e_rdata;

  assign e_wr    = in_acc && (operation_i == OpEdge) &&
                   ({26'd0, edge_slot_i} < 32'(EdgeDepth));
  assign e_waddr = EAW'(edge_slot_i);

  always_comb begin
    e_rd    = 1'b0;
    e_raddr = '0;
    case (state_q)
      S_E0: begin
        e_rd = 1'b1;
      end
      S_E1: begin
        e_rd    = 1'b1;
        e_raddr = EAW'(1);
      end
      S_E2: begin
        e_rd    = 1'b1;
        e_raddr = EAW'(f_q) + EAW'(2);
      end
      S_NEXT: begin
        e_rd    = 1'b1;
        e_raddr = EAW'(f_q) + EAW'(3);
      end
      default: ;
    endcase
  end

  mfb_edge_mem #(.Depth(EdgeDepth), .AddrW(EAW)) u_edge (
    .clk_i     (clk_i),
    .wr_en_i   (e_wr),
    .wr_addr_i (e_waddr),
    .wr_data_i (edge_bin_i),
    .rd_en_i   (e_rd),
    .rd_addr_i (e_raddr),
    .rd_data_o (e_rdata)
  );

  // accumulator RAM
  logic               a_rd, a_wr, a_clr;
  logic [EnergyW-1:0] a_rdata, a_wdata;
  logic [EnergyW:0]   sum;
  logic               em_load;

  assign sum     = {1'b0, a_rdata} + (EnergyW + 1)'(prod_q[ProdW-1:16]);
  assign a_wdata = sum[EnergyW] ? EnergyMax : sum[EnergyW-1:0];
  assign a_rd    = (state_q == S_MUL) || (state_q == S_EMRD);
  assign a_wr    = (state_q == S_ADD);
  assign em_load = (state_q == S_EMWR) && (!out_valid_q || !out_stall_i);
  assign a_clr   = em_load && last_f;

  mfb_acc_mem #(.Depth(MAX_FILTERS), .AddrW(FW)) u_acc (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (a_clr),
    .wr_en_i   (a_wr),
    .wr_addr_i (f_q),
    .wr_data_i (a_wdata),
    .rd_en_i   (a_rd),
    .rd_addr_i (f_q),
    .rd_data_o (a_rdata)
  );

  // filter coverage and weight setup
  logic [EdgeW:0]   lo, hi, kx, lx, cx, rx;
  logic             covered, single, rising;
  logic [NumW-1:0]  d_num;
  logic [DenW-1:0]  d_den;
  logic [EdgeW-1:0] span, side;
  logic             d_start, d_done;
  logic [QuotW-1:0] d_quot;

  always_comb begin
    kx      = {1'b0, k_q};
    lx      = {1'b0, l_q};
    cx      = {1'b0, c_q};
    rx      = {1'b0, r_q};
    lo      = lx + 1'b1;
    hi      = (rx >= lx + 2'd2) ? rx - 1'b1 : lo;
    covered = (kx >= lo) && (kx <= hi);
    single  = (hi == lo);
    rising  = (kx <= cx);
    span    = r_q - l_q;
    side    = rising ? c_q - l_q : r_q - c_q;
    d_num   = rising ? {k_q - l_q, 1'b0} : {r_q - k_q, 1'b0};
    d_den   = span * side;
  end

  assign d_start = (state_q == S_SETUP) && covered && !single;

  mfb_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (d_start),
    .num_i   (d_num),
    .den_i   (d_den),
    .done_o  (d_done),
    .quot_o  (d_quot)
  );

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      f_q         <= '0;
      out_valid_q <= 1'b0;
      l_q         <= '0;
      c_q         <= '0;
      r_q         <= '0;
      k_q         <= '0;
      power_q     <= '0;
      last_q      <= 1'b0;
      w_q         <= '0;
      prod_q      <= '0;
      fnum_q      <= '0;
      energy_q    <= '0;
      lastf_q     <= 1'b0;
    end else begin
      if (em_load) begin
        out_valid_q <= 1'b1;
        fnum_q      <= 5'(f_q);
        energy_q    <= a_rdata;
        lastf_q     <= last_f;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_acc && (operation_i == OpBin)) begin
            k_q     <= bin_index_i;
            power_q <= power_i;
            last_q  <= last_bin_i;
            f_q     <= '0;
            if (bin_ok) begin
              state_q <= S_E0;
            end else if (last_bin_i) begin
              state_q <= S_EMRD;
            end
          end
        end
        S_E0: state_q <= S_E1;
        S_E1: begin
          l_q     <= e_rdata;
          state_q <= S_E2;
        end
        S_E2: begin
          c_q     <= e_rdata;
          state_q <= S_EVAL;
        end
        S_EVAL: begin
          r_q     <= e_rdata;
          state_q <= S_SETUP;
        end
        S_SETUP: begin
          if (!covered) begin
            if (last_f) begin
              f_q     <= '0;
              state_q <= last_q ? S_EMRD : S_IDLE;
            end else begin
              state_q <= S_NEXT;
            end
          end else if (single) begin
            w_q     <= WeightOne;
            state_q <= S_MUL;
          end else begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (d_done) begin
            w_q     <= WeightW'(d_quot);
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          prod_q  <= ProdW'(power_q) * ProdW'(w_q);
          state_q <= S_ADD;
        end
        S_ADD: begin
          if (last_f) begin
            f_q     <= '0;
            state_q <= last_q ? S_EMRD : S_IDLE;
          end else begin
            state_q <= S_NEXT;
          end
        end
        S_NEXT: begin
          // slide the edge window by one filter
          l_q     <= c_q;
          c_q     <= r_q;
          f_q     <= f_q + 1'b1;
          state_q <= S_EVAL;
        end
        S_EMRD: state_q <= S_EMWR;
        S_EMWR: begin
          if (em_load) begin
            if (last_f) begin
              f_q     <= '0;
              state_q <= S_IDLE;
            end else begin
              f_q     <= f_q + 1'b1;
              state_q <= S_EMRD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign filter_number_o = fnum_q;
  assign energy_o        = energy_q;
  assign last_filter_o   = lastf_q;

endmodule

[bench/mfb_checker.sv]
// Checker for the mel filterbank accumulator: watches both item channels,
// predicts filter energies and compares them. Depends on mfb_pkg.
module mfb_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_nf_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        operation_i,
  input  logic [5:0]  edge_slot_i,
  input  logic [9:0]  edge_bin_i,
  input  logic [9:0]  bin_index_i,
  input  logic [31:0] power_i,
  input  logic        last_bin_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [4:0]  filter_number_i,
  input  logic [47:0] energy_i,
  input  logic        last_filter_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import mfb_pkg::*;

  typedef struct packed {
    logic [4:0]  fnum;
    logic [47:0] energy;
    logic        last;
  } energy_item_t;

  logic [9:0]  edges [34];
  logic [47:0] acc [32];
  logic [5:0]  nf_reg;
  energy_item_t energy_q[$];

  assign pending_o = energy_q.size();

  function automatic int unsigned nf_used();
    if (nf_reg < 1) return 1;
    if (nf_reg > 32) return 32;
    return nf_reg;
  endfunction

  function automatic longint unsigned tri_weight(int unsigned f, int unsigned k);
    longint unsigned l, c, r, lo, hi, num, den;
    l = edges[f]; c = edges[f+1]; r = edges[f+2];
    lo = l + 1;
    hi = (r >= l + 2) ? r - 1 : lo;
    if (k < lo || k > hi) return 0;
    if (hi == lo) return 65536;
    if (k <= c) begin
      num = 2 * (k - l) * 65536; den = (r - l) * (c - l);
    end else begin
      num = 2 * (r - k) * 65536; den = (r - l) * (r - c);
    end
    if (den == 0) return 0;
    return num / den;
  endfunction

  task automatic report(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    nf_reg = NumFiltRst;
    foreach (acc[i]) acc[i] = '0;
    foreach (edges[i]) edges[i] = '0;
  end

  always @(posedge clk_i) begin
    longint unsigned w, sum;
    energy_item_t got, exp_item;
    if (rst_ni) begin
      if (cfg_we_i) nf_reg <= cfg_nf_i;
      if (in_valid_i && !in_stall_i) begin
        if (operation_i == OpEdge) begin
          if (edge_slot_i < 34) edges[edge_slot_i] = edge_bin_i;
        end else begin
          for (int unsigned f = 0; f < nf_used(); f++) begin
            w = tri_weight(f, bin_index_i);
            if (w != 0) begin
              sum = acc[f] + ((longint'(power_i) * w) >> 16);
              acc[f] = (sum > EnergyMax) ? EnergyMax : sum[47:0];
            end
          end
          if (last_bin_i) begin
            for (int unsigned f = 0; f < nf_used(); f++)
              energy_q.push_back('{f[4:0], acc[f], f + 1 == nf_used()});
            foreach (acc[i]) acc[i] = '0;
          end
        end
      end
      if (out_valid_i && !out_stall_i) begin
        got = '{filter_number_i, energy_i, last_filter_i};
        if (energy_q.size() == 0) report("result item with none expected");
        else begin
          exp_item = energy_q.pop_front();
          if (got.fnum !== exp_item.fnum)
            report($sformatf("filter %0d exp %0d", got.fnum, exp_item.fnum));
          if (got.energy !== exp_item.energy)
            report($sformatf("filter %0d energy %0h exp %0h", got.fnum, got.energy,
                             exp_item.energy));
          if (got.last !== exp_item.last)
            report($sformatf("filter %0d last %0b exp %0b", got.fnum, got.last,
                             exp_item.last));
        end
      end
    end
  end
endmodule

[bench/tb.sv]
// Testbench top for mel_filterbank_accumulator: drives edges, bins and the
// filter-count register. Depends on mfb_pkg, mfb_checker and the block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mfb_pkg::*;

  logic        clk_i, rst_ni;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        in_valid_i, in_stall_o;
  logic        operation_i, last_bin_i;
  logic [5:0]  edge_slot_i;
  logic [9:0]  edge_bin_i, bin_index_i;
  logic [31:0] power_i;
  logic        out_valid_o, out_stall_i;
  logic [4:0]  filter_number_o;
  logic [47:0] energy_o;
  logic        last_filter_o;
  int          fail_count, pending;
  logic        stall_free;   // disables stall pattern

  mel_filterbank_accumulator dut (.*);

  mfb_checker u_checker (
    .clk_i, .rst_ni,
    .cfg_we_i(psel && penable && pwrite && pready && paddr == 3'd0),
    .cfg_nf_i(pwdata[5:0]),
    .in_valid_i, .in_stall_i(in_stall_o), .operation_i, .edge_slot_i,
    .edge_bin_i, .bin_index_i, .power_i, .last_bin_i,
    .out_valid_i(out_valid_o), .out_stall_i, .filter_number_i(filter_number_o),
    .energy_i(energy_o), .last_filter_i(last_filter_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver stall: mix of free runs and random stall bursts.
  int stall_phase;
  initial stall_phase = 0;
  always @(posedge clk_i) begin
    stall_phase <= stall_phase + 1;
    if (stall_free) out_stall_i <= 1'b0;
    else if (stall_phase[7]) out_stall_i <= 1'b0;      // stretches with no stall
    else out_stall_i <= ($urandom_range(0, 3) == 0);
  end

  // Register write: setup cycle then access cycle.
  task automatic write_nf(logic [5:0] v);
    @(posedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {RegNumFilters, 2'b00};
    pwdata <= {$urandom()} & 32'hFFFF_FFC0 | {26'd0, v};
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  // Send one item, waiting for acceptance; random gap before it.
  // Valid stays high after acceptance so that items can follow back to back.
  task automatic send_item(logic op, logic [5:0] slot, logic [9:0] eb,
                           logic [9:0] k, logic [31:0] pw, logic lb);
    if ($urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i <= 1; operation_i <= op; edge_slot_i <= slot;
    edge_bin_i <= eb; bin_index_i <= k; power_i <= pw; last_bin_i <= lb;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // Edge set: nondecreasing bins in a small window, sometimes degenerate.
  task automatic load_edges(int unsigned base, int unsigned maxstep,
                            int unsigned nslots);
    int unsigned e;
    e = base;
    for (int s = 0; s < int'(nslots); s++) begin
      send_item(OpEdge, s[5:0], e[9:0], 10'($urandom()), $urandom(),
                1'($urandom()));
      e = e + $urandom_range(0, maxstep);
      if (e > 1023) e = 1023;
    end
  endtask

  task automatic frame(int unsigned nbins, int unsigned lo, int unsigned hi,
                       logic big_power);
    logic [31:0] pw;
    for (int unsigned b = 0; b < nbins; b++) begin
      pw = big_power ? 32'hFFFF_FFFF - $urandom_range(0, 15) : $urandom();
      send_item(OpBin, 6'($urandom()), 10'($urandom()),
                10'($urandom_range(lo, hi)), pw, b + 1 == nbins);
    end
  endtask

  initial begin
    logic [5:0] nf_set [5];
    rst_ni = 0; psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    in_valid_i = 0; operation_i = 0; edge_slot_i = 0; edge_bin_i = 0;
    bin_index_i = 0; power_i = 0; last_bin_i = 0; out_stall_i = 0;
    stall_free = 1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: reset count of 24, steep edges, extreme powers.
    load_edges(0, 3, 34);
    send_item(OpEdge, 6'd34, 10'h3FF, 10'd0, 32'd0, 1'b1); // out-of-range slot
    send_item(OpEdge, 6'd63, 10'h155, 10'd0, 32'd0, 1'b0);
    send_item(OpBin, 6'd0, 10'd0, 10'd1, 32'hFFFF_FFFF, 1'b0);
    send_item(OpBin, 6'd0, 10'd0, 10'd1, 32'hFFFF_FFFF, 1'b0); // repeat bin
    send_item(OpBin, 6'd0, 10'd0, 10'd0, 32'h0, 1'b0);
    send_item(OpBin, 6'h3F, 10'h3FF, 10'd1023, 32'hFFFF_FFFF, 1'b1);
    wait_drained();
    stall_free = 0;
    write_nf(6'd1);
    // single filter, flat edges (degenerate case), power max
    for (int s = 0; s < 3; s++)
      send_item(OpEdge, s[5:0], 10'd5, 10'd0, 32'd0, 1'b0);
    send_item(OpBin, 6'd0, 10'd0, 10'd6, 32'hFFFF_FFFF, 1'b0);
    send_item(OpBin, 6'd0, 10'd0, 10'd6, 32'hAAAA_5555, 1'b1);
    wait_drained();
    write_nf(6'd0);                               // clamps to one
    send_item(OpBin, 6'd0, 10'd0, 10'd6, 32'h5555_AAAA, 1'b1);
    wait_drained();
    write_nf(6'd63);                              // clamps to 32
    load_edges(1000, 1, 34);
    send_item(OpBin, 6'd0, 10'd0, 10'd1020, 32'h1234_5678, 1'b1);
    wait_drained();

    // Random frames across settings; only the edges in use are reloaded.
    nf_set = '{6'd32, 6'd2, 6'd7, 6'd17, 6'd31};
    for (int ph = 0; ph < 5; ph++) begin
      int unsigned base, step, nfv;
      nfv = nf_set[ph];
      write_nf(nfv[5:0]);
      base = $urandom_range(0, 700);
      step = $urandom_range(0, 6);
      load_edges(base, step, nfv + 2);
      repeat (2) begin
        frame($urandom_range(3, 9), base, base + 34 * step + 3, ph == 3);
        if ($urandom_range(0, 2) == 0)
          send_item(OpEdge, 6'($urandom_range(34, 63)), 10'($urandom()),
                    10'd0, 32'd0, 1'b1);
      end
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("mel_filterbank_accumulator test passed");
    end else begin
      $display("mel_filterbank_accumulator test failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("mel_filterbank_accumulator test failed");
    $finish;
  end
endmodule
